@@ rtl/core/heightmap_bilinear_sampler_macros.svh @@
// ============================================================================
// Height-map sampler assertion macros
// Shared concurrent assertion forms for the sampler RTL.
// ============================================================================
`ifndef HEIGHTMAP_BILINEAR_SAMPLER_MACROS_SVH
`define HEIGHTMAP_BILINEAR_SAMPLER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HBS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/hbs_pkg.sv @@
// ============================================================================
// hbs_pkg
// Types and constants shared by the height-map bilinear sampler.
// ============================================================================
package hbs_pkg;

  // Default geometry
  localparam int GRID_SIDE_DEF = 256;
  localparam int FRAC_BITS_DEF = 8;

  // Fixed field widths
  localparam int HEIGHT_W = 16;
  localparam int COORD_W  = 16;
  localparam int WIDX_W   = 8;
  localparam int OUT_W    = 24;
  localparam int OUT_FRAC = 8;

  // Item kind codes
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Corner taps: bit 0 selects the next column, bit 1 the next row
  localparam logic [1:0] TAP_FIRST = 2'd0;
  localparam logic [1:0] TAP_LAST  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DRAIN,
    ST_DELIVER
  } state_e;

  typedef struct packed {
    logic                kind;
    logic [COORD_W-1:0]  col_coord;
    logic [COORD_W-1:0]  row_coord;
    logic [WIDX_W-1:0]   write_col;
    logic [WIDX_W-1:0]   write_row;
    logic [HEIGHT_W-1:0] height_in;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] height_out;
    logic             edge_clamped;
  } out_item_t;

endpackage

@@ rtl/core/hbs_ram.sv @@
// ============================================================================
// hbs_ram
// Generic single-port RAM, one write or one read per cycle, registered read.
// ============================================================================
module hbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage array and read register
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/heightmap_bilinear_sampler.sv @@
// ============================================================================
// heightmap_bilinear_sampler
// Height grid in one RAM; queries return the bilinear blend of four entries.
// ============================================================================
//
//   Channel | Direction | Handshake               | Payload
//   --------+-----------+-------------------------+-----------------------
//   in      | input     | in_valid_i / in_stall_o | in_item_i  (in_item_t)
//   out     | output    | out_valid_o/out_stall_i | out_item_o (out_item_t)
//
// A write transfer goes straight into the RAM; one outside the grid is dropped.
// A query runs four corner reads through the single RAM port,
// then a multiply stage and an accumulate stage, then the output load.
// The RAM port reads one corner per cycle.
// rst_ni clears control state only; the height RAM is undefined until written.
// A stalled output holds the finished query in DELIVER until the register frees.
//
`include "heightmap_bilinear_sampler_macros.svh"

module heightmap_bilinear_sampler
  import hbs_pkg::*;
#(
  parameter int GRID_SIDE = GRID_SIDE_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int CW    = $clog2(GRID_SIDE);
  localparam int AW    = 2 * CW;
  localparam int FR_W  = FRAC_BITS + 1;
  localparam int WT_W  = 2 * FRAC_BITS + 1;
  localparam int ACC_W = HEIGHT_W + 2 * FRAC_BITS;
  localparam int SC_W  = ACC_W + OUT_FRAC;
  localparam int WX_W  = CW + WIDX_W;

  localparam logic [FR_W-1:0] UNIT = {1'b1, {FRAC_BITS{1'b0}}};

  state_e state_q, state_d;

  // Input decode
  logic in_xfer, wr_xfer, qry_xfer;
  assign in_xfer  = in_valid_i && !in_stall_o;
  assign wr_xfer  = in_xfer && (in_item_i.kind == KIND_WRITE);
  assign qry_xfer = in_xfer && (in_item_i.kind == KIND_QUERY);

  // Write address, extended so any grid size fits
  logic [WX_W-1:0] wc_ext, wr_ext;
  logic            wr_in_grid;
  assign wc_ext     = WX_W'(in_item_i.write_col);
  assign wr_ext     = WX_W'(in_item_i.write_row);
  assign wr_in_grid = (wc_ext < WX_W'(GRID_SIDE)) && (wr_ext < WX_W'(GRID_SIDE));

  // Coordinate split with edge clamp
  logic [COORD_W:0] col_whole, row_whole;
  logic             col_clamp, row_clamp;
  logic [CW-1:0]    col_cell, row_cell;
  logic [FR_W-1:0]  col_frac, row_frac;

  assign col_whole = {1'b0, in_item_i.col_coord} >> FRAC_BITS;
  assign row_whole = {1'b0, in_item_i.row_coord} >> FRAC_BITS;
  assign col_clamp = col_whole >= (COORD_W + 1)'(GRID_SIDE - 1);
  assign row_clamp = row_whole >= (COORD_W + 1)'(GRID_SIDE - 1);
  assign col_cell  = col_clamp ? CW'(GRID_SIDE - 2) : col_whole[CW-1:0];
  assign row_cell  = row_clamp ? CW'(GRID_SIDE - 2) : row_whole[CW-1:0];
  assign col_frac  = col_clamp ? UNIT : {1'b0, in_item_i.col_coord[FRAC_BITS-1:0]};
  assign row_frac  = row_clamp ? UNIT : {1'b0, in_item_i.row_coord[FRAC_BITS-1:0]};

  // Query context
  logic [CW-1:0]   col_q, row_q;
  logic [FR_W-1:0] fc_q, fr_q;
  logic            clamp_q;
  logic [1:0]      tap_q;

  // Corner address and weight for the current tap
  logic [CW-1:0]       rd_col, rd_row;
  logic [FR_W-1:0]     wt_a, wt_b;
  logic [2*FR_W-1:0]   wt_full;
  assign rd_col  = col_q + CW'(tap_q[0]);
  assign rd_row  = row_q + CW'(tap_q[1]);
  assign wt_a    = tap_q[0] ? fc_q : UNIT - fc_q;
  assign wt_b    = tap_q[1] ? fr_q : UNIT - fr_q;
  assign wt_full = wt_a * wt_b;

  // RAM port: writes in IDLE, corner reads in FETCH
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_addr;
  logic [HEIGHT_W-1:0] ram_rdata;

  assign ram_we   = wr_xfer && wr_in_grid;
  assign ram_re   = (state_q == ST_FETCH);
  assign ram_addr = ram_we ? {wr_ext[CW-1:0], wc_ext[CW-1:0]} : {rd_row, rd_col};

  hbs_ram #(
    .WIDTH (HEIGHT_W),
    .DEPTH (2 ** AW)
  ) u_height_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (in_item_i.height_in),
    .rdata_o (ram_rdata)
  );

  // Read / multiply / accumulate pipeline
  logic                rd_vld_q, rd_last_q, prod_vld_q, prod_last_q;
  logic [WT_W-1:0]     weight_q;
  logic [ACC_W:0]      prod_full;
  logic [ACC_W-1:0]    prod_q, acc_q;
  logic                out_valid_q;
  out_item_t           out_q;
  logic                out_load;
  logic [SC_W-1:0]     scaled;

  assign prod_full = ram_rdata * weight_q;
  assign scaled    = {acc_q, {OUT_FRAC{1'b0}}} >> (2 * FRAC_BITS);
  assign out_load  = (state_q == ST_DELIVER) && (!out_valid_q || !out_stall_i);

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and input stall
  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (qry_xfer) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (tap_q == TAP_LAST) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (prod_vld_q && prod_last_q) begin
          state_d = ST_DELIVER;
        end
      end
      ST_DELIVER: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q       <= TAP_FIRST;
      rd_vld_q    <= 1'b0;
      rd_last_q   <= 1'b0;
      prod_vld_q  <= 1'b0;
      prod_last_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (qry_xfer) begin
        tap_q <= TAP_FIRST;
      end else if (ram_re) begin
        tap_q <= tap_q + 2'd1;
      end
      rd_vld_q    <= ram_re;
      rd_last_q   <= ram_re && (tap_q == TAP_LAST);
      prod_vld_q  <= rd_vld_q;
      prod_last_q <= rd_last_q;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (qry_xfer) begin
      col_q   <= col_cell;
      row_q   <= row_cell;
      fc_q    <= col_frac;
      fr_q    <= row_frac;
      clamp_q <= col_clamp || row_clamp;
      acc_q   <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + prod_q;
    end
    weight_q <= wt_full[WT_W-1:0];
    prod_q   <= prod_full[ACC_W-1:0];
    if (out_load) begin
      out_q.height_out   <= scaled[OUT_W-1:0];
      out_q.edge_clamped <= clamp_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Checks
  `HBS_ASSERT_IMPL(a_no_read_on_write, clk_i, rst_ni, ram_we, !ram_re, "read during write")
  `HBS_ASSERT_IMPL(a_prod_in_query, clk_i, rst_ni, prod_vld_q,
                   (state_q == ST_FETCH) || (state_q == ST_DRAIN), "product outside query")
  `HBS_ASSERT_NEXT(a_last_to_deliver, clk_i, rst_ni,
                   (state_q == ST_DRAIN) && prod_vld_q && prod_last_q,
                   state_q == ST_DELIVER, "last corner did not finish query")
  `HBS_ASSERT_NEXT(a_fetch_four, clk_i, rst_ni, qry_xfer,
                   (state_q == ST_FETCH) && (tap_q == TAP_FIRST), "query did not start fetch")

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb: height-map bilinear sampler testbench
// Loads height entries and queries positions through the valid/stall input
// channel, blends the four surrounding heights in a local predictor and
// checks every query result field by field, with random bursts on the input
// side and a changing stall pattern on the output side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import hbs_pkg::*;

  localparam int GRID        = GRID_SIDE_DEF;
  localparam int FRAC        = FRAC_BITS_DEF;
  localparam int UNIT        = 1 << FRAC;
  localparam int ITEM_TARGET = 1950;
  localparam int SETTLE_CYC  = 24;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  heightmap_bilinear_sampler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Pending transfers, the mirrored height grid and the expected blends
  in_item_t        req_q[$];
  out_item_t       heights_due[$];
  logic [15:0]     height_mirror [0:GRID*GRID-1];
  bit              planned [0:GRID*GRID-1];
  logic [15:0]     cells_seen[$];
  int              total_items;
  int              accepted_cnt;
  int              write_cnt;
  int              query_cnt;
  int              clamp_cnt;
  int              checked_cnt;
  int              err_cnt;

  // Cell index and fraction of one axis; the last cell is clamped to the edge
  function automatic bit split_axis(input logic [COORD_W-1:0] coord,
                                    output int idx, output int frac);
    int whole;
    whole = coord >> FRAC;
    if (whole >= GRID - 1) begin
      idx  = GRID - 2;
      frac = UNIT;
      return 1'b1;
    end
    idx  = whole;
    frac = coord & (UNIT - 1);
    return 1'b0;
  endfunction

  // Exact bilinear sum of the four corners, truncated to OUT_FRAC bits
  function automatic out_item_t blend_height(in_item_t q);
    out_item_t        res;
    int               c, r, fc, fr;
    bit               clamped;
    longint unsigned  tl, tr, bl, br, sum, h;
    clamped = split_axis(q.col_coord, c, fc);
    clamped |= split_axis(q.row_coord, r, fr);
    tl  = height_mirror[r * GRID + c];
    tr  = height_mirror[r * GRID + c + 1];
    bl  = height_mirror[(r + 1) * GRID + c];
    br  = height_mirror[(r + 1) * GRID + c + 1];
    sum = tl * (UNIT - fc) * (UNIT - fr) + tr * fc * (UNIT - fr)
        + bl * (UNIT - fc) * fr + br * fc * fr;
    if (2 * FRAC >= OUT_FRAC) h = sum >> (2 * FRAC - OUT_FRAC);
    else h = sum << (OUT_FRAC - 2 * FRAC);
    res.height_out   = h[OUT_W-1:0];
    res.edge_clamped = clamped;
    return res;
  endfunction

  // Apply one accepted transfer to the mirror or the expectation queue
  task automatic take_item(in_item_t it);
    if (it.kind == KIND_WRITE) begin
      write_cnt++;
      if (it.write_col < GRID && it.write_row < GRID)
        height_mirror[it.write_row * GRID + it.write_col] = it.height_in;
    end else begin
      query_cnt++;
      heights_due = {heights_due, blend_height(it)};
    end
  endtask

  task automatic flag(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Stimulus builders; query fields carry noise on writes and vice versa
  task automatic push_write(int row, int col, logic [15:0] h);
    in_item_t it;
    it.kind      = KIND_WRITE;
    it.col_coord = 16'($urandom);
    it.row_coord = 16'($urandom);
    it.write_col = 8'(col);
    it.write_row = 8'(row);
    it.height_in = h;
    planned[row * GRID + col] = 1'b1;
    req_q = {req_q, it};
  endtask

  task automatic push_query(logic [15:0] col, logic [15:0] row);
    in_item_t it;
    int       c, r, fc, fr;
    void'(split_axis(col, c, fc));
    void'(split_axis(row, r, fr));
    // Every corner must hold a written value before it is read
    for (int dr = 0; dr < 2; dr++)
      for (int dc = 0; dc < 2; dc++)
        if (!planned[(r + dr) * GRID + c + dc])
          push_write(r + dr, c + dc, 16'($urandom));
    cells_seen = {cells_seen, {row[15:8], col[15:8]}};
    it.kind      = KIND_QUERY;
    it.col_coord = col;
    it.row_coord = row;
    it.write_col = 8'($urandom);
    it.write_row = 8'($urandom);
    it.height_in = 16'($urandom);
    req_q = {req_q, it};
  endtask

  // Input driver: bursts of random length separated by random gaps
  int burst_left;
  int gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid && !in_stall) begin
        accepted_cnt++;
        take_item(in_item);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0 || req_q.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          in_valid <= 1'b1;
          in_item  <= req_q.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end
        end
      end
    end
  end

  // Output stall pattern: free-flowing, random, or mostly stalled spans
  int stall_mode;
  int stall_span;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      stall_mode = 0;
      stall_span = 0;
    end else begin
      if (stall_span == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_span = $urandom_range(20, 200);
      end else begin
        stall_span--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= 1'($urandom_range(0, 1));
        default: out_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Result monitor: each transfer against the oldest expected blend
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (heights_due.size() == 0) begin
        flag($sformatf("unexpected result height_out=%h edge_clamped=%b",
                       out_item.height_out, out_item.edge_clamped));
      end else begin
        want = heights_due.pop_front();
        checked_cnt++;
        if (want.edge_clamped) clamp_cnt++;
        if (out_item.height_out !== want.height_out)
          flag($sformatf("height_out exp %h got %h", want.height_out,
                         out_item.height_out));
        if (out_item.edge_clamped !== want.edge_clamped)
          flag($sformatf("edge_clamped exp %b got %b", want.edge_clamped,
                         out_item.edge_clamped));
      end
    end
  end

  initial begin
    int          pick;
    logic [15:0] qc;
    logic [15:0] qr;
    logic [15:0] seen_pos;

    // Directed: full-scale corners, fraction extremes and every clamp case
    push_write(0, 0, 16'hFFFF);
    push_write(0, 1, 16'h0000);
    push_write(1, 0, 16'h0000);
    push_write(1, 1, 16'hFFFF);
    push_query(16'h0000, 16'h0000);
    push_query(16'h00FF, 16'h00FF);
    push_query(16'h0080, 16'h0040);
    push_query(16'hFFFF, 16'hFFFF);
    push_query(16'hFF00, 16'h0010);
    push_query(16'h0010, 16'hFF00);
    push_query(16'hFEFF, 16'hFEFF);

    // Random: mostly queries on written cells, some edges, some overwrites
    while (req_q.size() < ITEM_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick <= 1) begin
        push_query(16'($urandom), 16'($urandom));
      end else if (pick <= 5) begin
        seen_pos = cells_seen[$urandom_range(0, cells_seen.size() - 1)];
        qc       = {seen_pos[7:0], 8'($urandom)};
        qr       = {seen_pos[15:8], 8'($urandom)};
        push_query(qc, qr);
      end else if (pick <= 7) begin
        qc = 16'($urandom);
        qr = 16'($urandom);
        if ($urandom_range(0, 1)) qc[15:8] = 8'($urandom_range(GRID - 3, GRID - 1));
        if ($urandom_range(0, 1)) qr[15:8] = 8'($urandom_range(GRID - 3, GRID - 1));
        push_query(qc, qr);
      end else begin
        seen_pos = cells_seen[$urandom_range(0, cells_seen.size() - 1)];
        push_write(($urandom_range(0, 1) ? 8'($urandom) : seen_pos[15:8]),
                   ($urandom_range(0, 1) ? 8'($urandom) : seen_pos[7:0]),
                   16'($urandom));
      end
    end
    total_items = req_q.size();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (accepted_cnt < total_items || heights_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);

    $display("Accepted %0d writes and %0d queries; %0d results checked.",
             write_cnt, query_cnt, checked_cnt);
    $display("%0d results were edge-clamped; %0d mismatches.", clamp_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Timeout: %0d of %0d transfers accepted, %0d results pending.",
             accepted_cnt, total_items, heights_due.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
